// ----- rtl/plb_pkg.sv -----
// ----------------------------------------------------------------------------
// Price level order book package
// Shared constants, codes and types of the order book blocks.
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam int LEVELS    = 4096;
    localparam int LVL_BITS  = $clog2(LEVELS);
    localparam int BEST_BITS = LVL_BITS + 1;
    localparam int QTY_BITS  = 32;

    localparam int IN_FIELD_BITS  = LVL_BITS + QTY_BITS;
    localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = BEST_BITS + LVL_BITS + 3 * QTY_BITS;
    localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W     = 2;

    localparam logic [LVL_BITS-1:0]  LVL_TOP   = LVL_BITS'(LEVELS - 1);
    localparam logic [LVL_BITS-1:0]  LVL_BOT   = '0;
    localparam logic [BEST_BITS-1:0] ASK_EMPTY = BEST_BITS'(LEVELS);

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;
    localparam logic SIDE_BID   = 1'b0;
    localparam logic SIDE_ASK   = 1'b1;

    typedef struct packed {
        logic                action;
        logic                side;
        logic [LVL_BITS-1:0] level;
        logic [QTY_BITS-1:0] quantity;
    } t_request;

    typedef struct packed {
        logic                we;
        logic [LVL_BITS-1:0] waddr;
        logic [QTY_BITS-1:0] wdata;
        logic [LVL_BITS-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [QTY_BITS-1:0]  level_quantity;
        logic [QTY_BITS-1:0]  best_bid_quantity;
        logic [LVL_BITS-1:0]  best_bid_level;
        logic [QTY_BITS-1:0]  best_ask_quantity;
        logic [BEST_BITS-1:0] best_ask_level;
    } t_result;

endpackage

// ----- rtl/price_level_order_book.sv -----
// ----------------------------------------------------------------------------
// Price level order book
// Bid and ask level stores with running best levels and a streaming port.
// ----------------------------------------------------------------------------
// Clearing the best level, except at the book edge, starts a scan of that
// side's level store, one level at a time, over up to 4095 levels. A new
// request is taken only once the last result has passed to the output
// register, so scans and output stalls hold off the next request.
// Reset clears the best levels and starts a clearing pass through both level
// stores, during which no request is accepted.
module price_level_order_book import plb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: tick_level (12), quantity (32), zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: action (1), side (1).
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: best_ask_level (13), best_ask_quantity (32),
    // best_bid_level (12), best_bid_quantity (32), level_quantity (32), zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_request            req;
    t_ram_req            ask_ram;
    t_ram_req            bid_ram;
    logic [QTY_BITS-1:0] ask_rdata;
    logic [QTY_BITS-1:0] bid_rdata;
    logic                res_valid;
    logic                res_ready;
    t_result             res;
    logic                clearing;

    logic                r_out_valid;
    t_result             r_out;

    assign req.action   = s_axis_tuser[0];
    assign req.side     = s_axis_tuser[1];
    assign req.level    = s_axis_tdata[LVL_BITS-1:0];
    assign req.quantity = s_axis_tdata[LVL_BITS +: QTY_BITS];

    plb_ram #(
        .WIDTH (QTY_BITS),
        .DEPTH (LEVELS)
    ) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (ask_ram.we),
        .i_waddr (ask_ram.waddr),
        .i_wdata (ask_ram.wdata),
        .i_raddr (ask_ram.raddr),
        .o_rdata (ask_rdata)
    );

    plb_ram #(
        .WIDTH (QTY_BITS),
        .DEPTH (LEVELS)
    ) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (bid_ram.we),
        .i_waddr (bid_ram.waddr),
        .i_wdata (bid_ram.wdata),
        .i_raddr (bid_ram.raddr),
        .o_rdata (bid_rdata)
    );

    plb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_ask_ram   (ask_ram),
        .o_bid_ram   (bid_ram),
        .i_ask_rdata (ask_rdata),
        .i_bid_rdata (bid_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_clearing  (clearing)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_BITS){1'b0}}, r_out};

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_axis_tready
    ) else $error("request accepted during the clearing pass");

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("second request taken while one is in flight");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid
    ) else $error("finished result dropped before the output took it");

    a_best_ask_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.best_ask_level <= ASK_EMPTY)
    ) else $error("best ask level beyond the book edge");

    a_empty_ask_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.best_ask_level == ASK_EMPTY)
            |-> (r_out.best_ask_quantity == '0)
    ) else $error("empty ask side reports a quantity");

endmodule

// ----- rtl/plb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/plb_engine.sv -----
// ----------------------------------------------------------------------------
// Price level order book sequencer
// Clears both level stores after reset, then runs each request through
// write or read, best level update, level scan and best quantity fetch.
// ----------------------------------------------------------------------------
module plb_engine import plb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_request      i_req,
    output t_ram_req      o_ask_ram,
    output t_ram_req      o_bid_ram,
    input  logic [QTY_BITS-1:0] i_ask_rdata,
    input  logic [QTY_BITS-1:0] i_bid_rdata,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res,
    output logic          o_clearing
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_WRITE = 9'b000000100,
        S_QRY   = 9'b000001000,
        S_QGET  = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_BRD   = 9'b001000000,
        S_BGET  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state               r_state,     n_state;
    logic [LVL_BITS-1:0]  r_clr_addr,  n_clr_addr;
    logic                 r_side,      n_side;
    logic [LVL_BITS-1:0]  r_lvl,       n_lvl;
    logic [QTY_BITS-1:0]  r_qty,       n_qty;
    logic [QTY_BITS-1:0]  r_here,      n_here;
    logic [BEST_BITS-1:0] r_best_ask,  n_best_ask;
    logic [LVL_BITS-1:0]  r_best_bid,  n_best_bid;
    logic [LVL_BITS-1:0]  r_scan_addr, n_scan_addr;
    logic                 r_chk_pend,  n_chk_pend;
    logic [LVL_BITS-1:0]  r_chk_addr,  n_chk_addr;
    logic                 r_chk_last,  n_chk_last;
    logic [QTY_BITS-1:0]  r_baq,       n_baq;
    logic [QTY_BITS-1:0]  r_bbq,       n_bbq;

    logic [QTY_BITS-1:0]  scan_rdata;
    logic                 scan_hit;
    logic [BEST_BITS-1:0] lvl_ext;

    // The single zero compare is shared by every scan step.
    assign scan_rdata = (r_side == SIDE_ASK) ? i_ask_rdata : i_bid_rdata;
    assign scan_hit   = (scan_rdata != '0);
    assign lvl_ext    = {1'b0, r_lvl};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_side      = r_side;
        n_lvl       = r_lvl;
        n_qty       = r_qty;
        n_here      = r_here;
        n_best_ask  = r_best_ask;
        n_best_bid  = r_best_bid;
        n_scan_addr = r_scan_addr;
        n_chk_pend  = r_chk_pend;
        n_chk_addr  = r_chk_addr;
        n_chk_last  = r_chk_last;
        n_baq       = r_baq;
        n_bbq       = r_bbq;

        o_ask_ram.we    = 1'b0;
        o_ask_ram.waddr = r_lvl;
        o_ask_ram.wdata = r_qty;
        o_ask_ram.raddr = r_best_ask[LVL_BITS-1:0];
        o_bid_ram.we    = 1'b0;
        o_bid_ram.waddr = r_lvl;
        o_bid_ram.wdata = r_qty;
        o_bid_ram.raddr = r_best_bid;

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_ask_ram.we    = 1'b1;
                o_ask_ram.waddr = r_clr_addr;
                o_ask_ram.wdata = '0;
                o_bid_ram.we    = 1'b1;
                o_bid_ram.waddr = r_clr_addr;
                o_bid_ram.wdata = '0;
                n_clr_addr      = r_clr_addr + LVL_BITS'(1);
                if (r_clr_addr == LVL_TOP) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_side  = i_req.side;
                    n_lvl   = i_req.level;
                    n_qty   = i_req.quantity;
                    n_state = (i_req.action == ACT_QUERY) ? S_QRY : S_WRITE;
                end
            end
            S_WRITE: begin
                n_here     = r_qty;
                n_state    = S_BRD;
                n_chk_pend = 1'b0;
                if (r_side == SIDE_ASK) begin
                    o_ask_ram.we = 1'b1;
                    if (r_qty == '0) begin
                        if (lvl_ext == r_best_ask) begin
                            if (r_lvl == LVL_TOP) begin
                                n_best_ask = ASK_EMPTY;
                            end else begin
                                n_scan_addr = r_lvl + LVL_BITS'(1);
                                n_state     = S_SCAN;
                            end
                        end
                    end else if (r_best_ask > lvl_ext) begin
                        n_best_ask = lvl_ext;
                    end
                end else begin
                    o_bid_ram.we = 1'b1;
                    if (r_qty == '0) begin
                        if (r_lvl == r_best_bid && r_lvl != LVL_BOT) begin
                            n_scan_addr = r_lvl - LVL_BITS'(1);
                            n_state     = S_SCAN;
                        end
                    end else if (r_best_bid < r_lvl) begin
                        n_best_bid = r_lvl;
                    end
                end
            end
            S_QRY: begin
                o_ask_ram.raddr = r_lvl;
                o_bid_ram.raddr = r_lvl;
                n_state         = S_QGET;
            end
            S_QGET: begin
                n_here  = (r_side == SIDE_ASK) ? i_ask_rdata : i_bid_rdata;
                n_state = S_BRD;
            end
            S_SCAN: begin
                // Reads are issued one level per cycle; the data checked here
                // belongs to the level issued in the previous cycle.
                o_ask_ram.raddr = r_scan_addr;
                o_bid_ram.raddr = r_scan_addr;
                n_chk_pend      = 1'b1;
                n_chk_addr      = r_scan_addr;
                if (r_side == SIDE_ASK) begin
                    n_scan_addr = r_scan_addr + LVL_BITS'(1);
                    n_chk_last  = (r_scan_addr == LVL_TOP);
                end else begin
                    n_scan_addr = r_scan_addr - LVL_BITS'(1);
                    n_chk_last  = (r_scan_addr == LVL_BOT);
                end
                if (r_chk_pend) begin
                    if (scan_hit) begin
                        if (r_side == SIDE_ASK) begin
                            n_best_ask = {1'b0, r_chk_addr};
                        end else begin
                            n_best_bid = r_chk_addr;
                        end
                        n_state = S_BRD;
                    end else if (r_chk_last) begin
                        if (r_side == SIDE_ASK) begin
                            n_best_ask = ASK_EMPTY;
                        end else begin
                            n_best_bid = LVL_BOT;
                        end
                        n_state = S_BRD;
                    end
                end
            end
            S_BRD: begin
                n_state = S_BGET;
            end
            S_BGET: begin
                n_baq   = (r_best_ask == ASK_EMPTY) ? '0 : i_ask_rdata;
                n_bbq   = i_bid_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_best_ask <= ASK_EMPTY;
            r_best_bid <= LVL_BOT;
            r_chk_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_best_ask <= n_best_ask;
            r_best_bid <= n_best_bid;
            r_chk_pend <= n_chk_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side      <= n_side;
        r_lvl       <= n_lvl;
        r_qty       <= n_qty;
        r_here      <= n_here;
        r_scan_addr <= n_scan_addr;
        r_chk_addr  <= n_chk_addr;
        r_chk_last  <= n_chk_last;
        r_baq       <= n_baq;
        r_bbq       <= n_bbq;
    end

    assign o_res.best_ask_level    = r_best_ask;
    assign o_res.best_ask_quantity = r_baq;
    assign o_res.best_bid_level    = r_best_bid;
    assign o_res.best_bid_quantity = r_bbq;
    assign o_res.level_quantity    = r_here;
    assign o_clearing              = (r_state == S_CLEAR);

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Price level order book testbench
// Drives update and query requests into the order book over the stream port.
// A directed table covers the book edges, emptied sides and best-level
// removal, followed by random order flow concentrated around a mid price.
// Each result is checked field by field against a behavioral book that keeps
// its own level stores and best levels, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import plb_pkg::*;

    localparam int                  RANDOM_ORDERS = 650;
    localparam int                  MID_LO        = 1920;
    localparam logic [QTY_BITS-1:0] QTY_MAX       = '1;
    localparam int                  PLAN_ROWS     = 25;

    typedef struct packed {
        logic                 action;
        logic                 side;
        logic [LVL_BITS-1:0]  level;
        logic [QTY_BITS-1:0]  quantity;
        logic                 pinned;
        logic [BEST_BITS-1:0] ask_level;
        logic [QTY_BITS-1:0]  ask_qty;
        logic [LVL_BITS-1:0]  bid_level;
        logic [QTY_BITS-1:0]  bid_qty;
        logic [QTY_BITS-1:0]  level_qty;
    } t_plan_row;

    // Rows with the pinned flag carry the snapshot the book must report.
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{ACT_QUERY,  SIDE_BID, 12'd0,    32'd0,   1'b1,
          ASK_EMPTY, 32'd0, 12'd0, 32'd0, 32'd0},
        '{ACT_QUERY,  SIDE_ASK, 12'd4095, QTY_MAX, 1'b1,
          ASK_EMPTY, 32'd0, 12'd0, 32'd0, 32'd0},
        '{ACT_UPDATE, SIDE_ASK, 12'd4095, QTY_MAX, 1'b1,
          13'd4095, QTY_MAX, 12'd0, 32'd0, QTY_MAX},
        '{ACT_UPDATE, SIDE_BID, 12'd0,    32'd1,   1'b1,
          13'd4095, QTY_MAX, 12'd0, 32'd1, 32'd1},
        '{ACT_UPDATE, SIDE_BID, 12'd4095, 32'd5,   1'b1,
          13'd4095, QTY_MAX, 12'd4095, 32'd5, 32'd5},
        '{ACT_UPDATE, SIDE_ASK, 12'd0,    32'd7,   1'b1,
          13'd0, 32'd7, 12'd4095, 32'd5, 32'd7},
        '{ACT_UPDATE, SIDE_ASK, 12'd2000, 32'd3,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd2000, 32'd9,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd0,    32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd4095, 32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd2000, 32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd4095, 32'd0,   1'b1,
          ASK_EMPTY, 32'd0, 12'd2000, 32'd9, 32'd0},
        '{ACT_UPDATE, SIDE_BID, 12'd2000, 32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd0,    32'd0,   1'b1,
          ASK_EMPTY, 32'd0, 12'd0, 32'd0, 32'd0},
        '{ACT_UPDATE, SIDE_ASK, 12'd100,  32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd10,   32'd4,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd5,    32'd6,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd5,    32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_QUERY,  SIDE_BID, 12'd10,   32'hDEAD_BEEF, 1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd10,   32'h8000_0000, 1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd1,    32'h5555_5555, 1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd2,    32'hAAAA_AAAA, 1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_ASK, 12'd1,    32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_QUERY,  SIDE_ASK, 12'd2,    32'd0,   1'b0, '0, '0, '0, '0, '0},
        '{ACT_UPDATE, SIDE_BID, 12'd4094, 32'h0000_FFFF, 1'b0, '0, '0, '0, '0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: tick_level (12), quantity (32), zero fill.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // Fields from bit 0: action (1), side (1).
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: best_ask_level (13), best_ask_quantity (32),
    // best_bid_level (12), best_bid_quantity (32), level_quantity (32), zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [QTY_BITS-1:0]  ask_lots [LEVELS];
    logic [QTY_BITS-1:0]  bid_lots [LEVELS];
    logic [BEST_BITS-1:0] top_ask;
    logic [LVL_BITS-1:0]  top_bid;
    t_result              pending_snapshots [$];
    int                   errors = 0;
    bit                   steady = 1'b0;

    price_level_order_book dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_result apply_to_book(t_request r);
        t_result res;
        int      k;
        if (r.action == ACT_UPDATE) begin
            if (r.side == SIDE_ASK) begin
                ask_lots[r.level] = r.quantity;
                if (r.quantity == '0) begin
                    if (BEST_BITS'(r.level) == top_ask) begin
                        k = int'(r.level) + 1;
                        while (k < LEVELS && ask_lots[k] == '0) k++;
                        top_ask = BEST_BITS'(k);
                    end
                end else if (top_ask > BEST_BITS'(r.level)) begin
                    top_ask = BEST_BITS'(r.level);
                end
            end else begin
                bid_lots[r.level] = r.quantity;
                if (r.quantity == '0) begin
                    if (r.level == top_bid) begin
                        k = int'(r.level) - 1;
                        while (k > 0 && bid_lots[k] == '0) k--;
                        top_bid = (k < 0) ? LVL_BOT : LVL_BITS'(k);
                    end
                end else if (top_bid < r.level) begin
                    top_bid = r.level;
                end
            end
        end
        res.level_quantity    = (r.side == SIDE_ASK) ? ask_lots[r.level] : bid_lots[r.level];
        res.best_ask_level    = top_ask;
        res.best_ask_quantity = (top_ask == ASK_EMPTY) ? '0 : ask_lots[top_ask[LVL_BITS-1:0]];
        res.best_bid_level    = top_bid;
        res.best_bid_quantity = bid_lots[top_bid];
        return res;
    endfunction

    // Most order flow lands in a window around the mid price so that scans
    // stay short; the rest hits the book edges or any level.
    function automatic t_request random_order();
        t_request    r;
        int unsigned roll;
        r.action = ($urandom_range(99) < 20) ? ACT_QUERY : ACT_UPDATE;
        r.side   = 1'($urandom_range(1));
        roll     = $urandom_range(99);
        if (roll < 70) begin
            r.level = LVL_BITS'(MID_LO + $urandom_range(255));
        end else if (roll < 80) begin
            r.level = ($urandom_range(1) != 0) ? LVL_TOP - LVL_BITS'($urandom_range(1))
                                               : LVL_BOT + LVL_BITS'($urandom_range(1));
        end else begin
            r.level = LVL_BITS'($urandom_range(LEVELS - 1));
        end
        roll = $urandom_range(99);
        if (roll < 35) begin
            r.quantity = '0;
        end else if (roll < 43) begin
            r.quantity = QTY_MAX;
        end else if (roll < 48) begin
            r.quantity = 32'd1;
        end else begin
            r.quantity = $urandom;
        end
        if (r.action == ACT_UPDATE && $urandom_range(99) < 15) begin
            if (r.side == SIDE_ASK && top_ask != ASK_EMPTY) begin
                r.level    = top_ask[LVL_BITS-1:0];
                r.quantity = '0;
            end else if (r.side == SIDE_BID) begin
                r.level    = top_bid;
                r.quantity = '0;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string tag, input logic [QTY_BITS-1:0] want,
                               input logic [QTY_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
            errors++;
        end
    endtask

    initial begin
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[OUT_FIELD_BITS-1:0]);
                if (pending_snapshots.size() == 0) begin
                    $display("%0t: result with no request pending, actual %0h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = pending_snapshots.pop_front();
                    check_field("best_ask_level", QTY_BITS'(want.best_ask_level),
                                QTY_BITS'(got.best_ask_level));
                    check_field("best_ask_quantity", want.best_ask_quantity,
                                got.best_ask_quantity);
                    check_field("best_bid_level", QTY_BITS'(want.best_bid_level),
                                QTY_BITS'(got.best_bid_level));
                    check_field("best_bid_quantity", want.best_bid_quantity,
                                got.best_bid_quantity);
                    check_field("level_quantity", want.level_quantity, got.level_quantity);
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 12);
        end
    end

    initial begin
        t_request  r;
        t_result   snapshot;
        t_plan_row row;
        for (int n = 0; n < LEVELS; n++) begin
            ask_lots[n] = '0;
            bid_lots[n] = '0;
        end
        top_ask = ASK_EMPTY;
        top_bid = LVL_BOT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < PLAN_ROWS + RANDOM_ORDERS; i++) begin
            steady = (i >= 250 && i < 400);
            if (!steady && $urandom_range(99) < 12) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            row = PLAN[i % PLAN_ROWS];
            if (i < PLAN_ROWS) begin
                r.action   = row.action;
                r.side     = row.side;
                r.level    = row.level;
                r.quantity = row.quantity;
            end else begin
                r = random_order();
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= IN_TDATA_W'({r.quantity, r.level});
            s_axis_tuser  <= {r.side, r.action};
            do @(posedge i_clk); while (!s_axis_tready);
            snapshot = apply_to_book(r);
            if (i < PLAN_ROWS && row.pinned) begin
                snapshot.best_ask_level    = row.ask_level;
                snapshot.best_ask_quantity = row.ask_qty;
                snapshot.best_bid_level    = row.bid_level;
                snapshot.best_bid_quantity = row.bid_qty;
                snapshot.level_quantity    = row.level_qty;
            end
            pending_snapshots.push_back(snapshot);
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (pending_snapshots.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
